[rtl/cqd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqd_pkg
// Shared types and constants for the command queue with its done ring.
// ----------------------------------------------------------------------------
package cqd_pkg;

  localparam int QUEUE_DEPTH  = 64;
  localparam int DONE_DEPTH   = 128;
  localparam int PAYLOAD_BITS = 32;

  localparam int QPtrW  = $clog2(QUEUE_DEPTH);
  localparam int DPtrW  = $clog2(DONE_DEPTH);
  localparam int CountW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_ADD        = 3'd0,
    CMD_DISPATCH   = 3'd1,
    CMD_FINISH     = 3'd2,
    CMD_ISR_POP    = 3'd3,
    CMD_DRAIN      = 3'd4,
    CMD_FLUSH      = 3'd5,
    CMD_FLUSH_NEXT = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    logic [31:0]             id;
    logic [PAYLOAD_BITS-1:0] payload;
  } blk_entry_t;

  // what the accepted command still owes its result
  typedef struct packed {
    status_t status;
    logic    take;
    logic    drain;
  } pend_t;

endpackage

[rtl/cqd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqd_ram
// Simple dual-port RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module cqd_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/command_queue_with_done_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_queue_with_done_fifo
// Motion-command queue with a ring of completed ids.
// ----------------------------------------------------------------------------
// Each command item gives one result item. When a command is taken, the
// pointers and counts are updated and the block store or done store is
// written or read; the read data from that memory then lands in the result
// register once that register is free (not valid or not stalled). One
// command is in work at a time, so the block takes no new command until the
// last one has loaded its result; the result register holds a finished
// result while the next command is taken. Both stores are RAMs with a
// registered read and their contents are not cleared by reset.
module command_queue_with_done_fifo
  import cqd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  logic [2:0]        cmd,
  input  logic [31:0]       new_block_id,
  input  logic [31:0]       new_payload,
  input  logic              robot_idle,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [1:0]        status,
  output logic              block_valid,
  output logic [31:0]       out_block_id,
  output logic [31:0]       out_payload,
  output logic              done_valid,
  output logic [31:0]       done_id,
  output logic [CountW-1:0] queued_count,
  output logic [31:0]       running_id
);

  state_t state, state_next;

  logic [QPtrW-1:0]  write_pos, write_pos_next;
  logic [QPtrW-1:0]  read_pos, read_pos_next;
  logic [CountW-1:0] fill_level, fill_level_next;
  logic [31:0]       active_id, active_id_next;
  logic [DPtrW-1:0]  done_write_pos, done_write_pos_next;
  logic [DPtrW-1:0]  done_read_pos, done_read_pos_next;
  pend_t             pend, pend_next;

  logic       accept;
  logic       load;
  logic       blk_we, blk_re, done_we, done_re;
  blk_entry_t blk_wdata, blk_rdata;
  logic [31:0] done_rdata;
  logic [QPtrW-1:0] write_pos_inc, read_pos_inc;
  logic [DPtrW-1:0] done_write_inc, done_read_inc;

  // storage
  cqd_ram #(
    .Width ($bits(blk_entry_t)),
    .Depth (QUEUE_DEPTH)
  ) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (write_pos),
    .wdata (blk_wdata),
    .re    (blk_re),
    .raddr (read_pos),
    .rdata (blk_rdata)
  );

  cqd_ram #(
    .Width (32),
    .Depth (DONE_DEPTH)
  ) u_done_ram (
    .clk   (clk),
    .we    (done_we),
    .waddr (done_write_pos),
    .wdata (active_id),
    .re    (done_re),
    .raddr (done_read_pos),
    .rdata (done_rdata)
  );

  assign blk_wdata.id      = new_block_id;
  assign blk_wdata.payload = PAYLOAD_BITS'(new_payload);

  // state machine: next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (!res_valid || !res_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state machine: outputs
  always_comb begin
    cmd_stall = 1'b1;
    load      = 1'b0;
    unique case (state)
      S_IDLE: cmd_stall = 1'b0;
      S_READ: load = !res_valid || !res_stall;
      default: ;
    endcase
  end

  assign accept = cmd_valid && !cmd_stall;

  assign write_pos_inc  = (write_pos == QPtrW'(QUEUE_DEPTH - 1)) ? '0 : write_pos + 1'b1;
  assign read_pos_inc   = (read_pos == QPtrW'(QUEUE_DEPTH - 1)) ? '0 : read_pos + 1'b1;
  assign done_write_inc = (done_write_pos == DPtrW'(DONE_DEPTH - 1)) ? '0
                          : done_write_pos + 1'b1;
  assign done_read_inc  = (done_read_pos == DPtrW'(DONE_DEPTH - 1)) ? '0
                          : done_read_pos + 1'b1;

  // command decode at accept
  always_comb begin
    write_pos_next      = write_pos;
    read_pos_next       = read_pos;
    fill_level_next     = fill_level;
    active_id_next      = active_id;
    done_write_pos_next = done_write_pos;
    done_read_pos_next  = done_read_pos;
    pend_next           = pend;
    blk_we              = 1'b0;
    blk_re              = 1'b0;
    done_we             = 1'b0;
    done_re             = 1'b0;

    if (accept) begin
      pend_next.status = STAT_OK;
      pend_next.take   = 1'b0;
      pend_next.drain  = 1'b0;
      unique case (cmd) inside
        CMD_ADD: begin
          if (fill_level >= CountW'(QUEUE_DEPTH)) begin
            pend_next.status = STAT_FULL;
          end else begin
            blk_we          = 1'b1;
            write_pos_next  = write_pos_inc;
            fill_level_next = fill_level + 1'b1;
          end
        end
        CMD_DISPATCH, CMD_ISR_POP: begin
          if ((fill_level != '0) &&
              ((cmd == CMD_ISR_POP) || (robot_idle && (active_id == '0)))) begin
            blk_re          = 1'b1;
            pend_next.take  = 1'b1;
            read_pos_next   = read_pos_inc;
            fill_level_next = fill_level - 1'b1;
          end else begin
            pend_next.status = STAT_NONE;
          end
        end
        CMD_FINISH: begin
          if (active_id != '0) begin
            // a full done ring drops the id
            if (done_write_inc != done_read_pos) begin
              done_we             = 1'b1;
              done_write_pos_next = done_write_inc;
            end
            active_id_next = '0;
          end
        end
        CMD_DRAIN: begin
          if (done_write_pos != done_read_pos) begin
            done_re            = 1'b1;
            pend_next.drain    = 1'b1;
            done_read_pos_next = done_read_inc;
          end else begin
            pend_next.status = STAT_NONE;
          end
        end
        CMD_FLUSH: begin
          write_pos_next  = '0;
          read_pos_next   = '0;
          fill_level_next = '0;
          active_id_next  = '0;
        end
        CMD_FLUSH_NEXT: begin
          write_pos_next  = '0;
          read_pos_next   = '0;
          fill_level_next = '0;
        end
        default: ;
      endcase
    end else if (load && pend.take) begin
      // taken block becomes the running one
      active_id_next = blk_rdata.id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      write_pos      <= '0;
      read_pos       <= '0;
      fill_level     <= '0;
      active_id      <= '0;
      done_write_pos <= '0;
      done_read_pos  <= '0;
      pend           <= '0;
    end else begin
      state          <= state_next;
      write_pos      <= write_pos_next;
      read_pos       <= read_pos_next;
      fill_level     <= fill_level_next;
      active_id      <= active_id_next;
      done_write_pos <= done_write_pos_next;
      done_read_pos  <= done_read_pos_next;
      pend           <= pend_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status       <= pend.status;
      block_valid  <= pend.take;
      out_block_id <= pend.take ? blk_rdata.id : '0;
      out_payload  <= pend.take ? 32'(blk_rdata.payload) : '0;
      done_valid   <= pend.drain;
      done_id      <= pend.drain ? done_rdata : '0;
      queued_count <= fill_level;
      running_id   <= pend.take ? blk_rdata.id : active_id;
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the motion-command queue and its done ring against a cycle-free
// model kept in the bench. A driver offers command items in bursts, a monitor
// compares every result item with the oldest prediction, and the receiver
// stalls on its own pattern with two long holds.
// ----------------------------------------------------------------------------
module tb;
  import cqd_pkg::*;

  typedef struct {
    cmd_t        op;
    logic [31:0] id;
    logic [31:0] pay;
    logic        idle;
    bit          wait_empty;
  } cmd_item_t;

  typedef struct packed {
    status_t           status;
    logic              block_valid;
    logic [31:0]       block_id;
    logic [31:0]       payload;
    logic              done_valid;
    logic [31:0]       done_id;
    logic [CountW-1:0] queued;
    logic [31:0]       running;
  } cq_result_t;

  localparam int MaxCycles = 500000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cmd_valid = 1'b0;
  logic              cmd_stall;
  logic [2:0]        cmd = 3'd0;
  logic [31:0]       new_block_id = '0;
  logic [31:0]       new_payload = '0;
  logic              robot_idle = 1'b0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  logic [1:0]        status;
  logic              block_valid;
  logic [31:0]       out_block_id;
  logic [31:0]       out_payload;
  logic              done_valid;
  logic [31:0]       done_id;
  logic [CountW-1:0] queued_count;
  logic [31:0]       running_id;

  command_queue_with_done_fifo dut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .cmd          (cmd),
    .new_block_id (new_block_id),
    .new_payload  (new_payload),
    .robot_idle   (robot_idle),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .status       (status),
    .block_valid  (block_valid),
    .out_block_id (out_block_id),
    .out_payload  (out_payload),
    .done_valid   (done_valid),
    .done_id      (done_id),
    .queued_count (queued_count),
    .running_id   (running_id)
  );

  initial forever #2 clk = ~clk;

  cmd_item_t  pending_cmds[$];
  cq_result_t expected_results[$];

  // model state
  logic [31:0] blk_ids [QUEUE_DEPTH];
  logic [31:0] blk_pays[QUEUE_DEPTH];
  logic [31:0] done_ids[DONE_DEPTH];
  int          q_wr = 0, q_rd = 0, q_fill = 0;
  int          d_wr = 0, d_rd = 0;
  logic [31:0] run_id = '0;

  int n_sent = 0, n_got = 0, n_bad = 0;
  int n_full = 0, n_taken = 0, n_drained = 0, n_dropped = 0;
  int n_long_holds = 0, n_pauses = 0;

  task automatic take_next(inout cq_result_t r);
    r.block_valid = 1'b1;
    r.block_id    = blk_ids[q_rd];
    r.payload     = blk_pays[q_rd];
    run_id        = blk_ids[q_rd];
    q_rd          = (q_rd + 1) % QUEUE_DEPTH;
    q_fill--;
    n_taken++;
  endtask

  task automatic predict_command(input cmd_t op, input logic [31:0] nid,
                                 input logic [31:0] npay, input logic idle);
    cq_result_t r;
    int         nxt;
    r = '0;
    r.status = STAT_OK;
    case (op)
      CMD_ADD: begin
        if (q_fill >= QUEUE_DEPTH) begin
          r.status = STAT_FULL;
          n_full++;
        end else begin
          blk_ids[q_wr]  = nid;
          blk_pays[q_wr] = npay;
          q_wr = (q_wr + 1) % QUEUE_DEPTH;
          q_fill++;
        end
      end
      CMD_DISPATCH: begin
        if (idle && q_fill > 0 && run_id == 0) take_next(r);
        else r.status = STAT_NONE;
      end
      CMD_FINISH: begin
        if (run_id != 0) begin
          nxt = (d_wr + 1) % DONE_DEPTH;
          // ring keeps one slot free, a finish into a full ring is lost
          if (nxt != d_rd) begin
            done_ids[d_wr] = run_id;
            d_wr = nxt;
          end else begin
            n_dropped++;
          end
          run_id = '0;
        end
      end
      CMD_ISR_POP: begin
        if (q_fill > 0) take_next(r);
        else r.status = STAT_NONE;
      end
      CMD_DRAIN: begin
        if (d_wr != d_rd) begin
          r.done_valid = 1'b1;
          r.done_id    = done_ids[d_rd];
          d_rd = (d_rd + 1) % DONE_DEPTH;
          n_drained++;
        end else begin
          r.status = STAT_NONE;
        end
      end
      CMD_FLUSH: begin
        q_wr = 0; q_rd = 0; q_fill = 0;
        run_id = '0;
      end
      CMD_FLUSH_NEXT: begin
        q_wr = 0; q_rd = 0; q_fill = 0;
      end
      default: ;
    endcase
    r.queued  = q_fill[CountW-1:0];
    r.running = run_id;
    expected_results.push_back(r);
  endtask

  // driver: bursts of items with random gaps
  int burst_left = 8, gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        predict_command(cmd_t'(cmd), new_block_id, new_payload, robot_idle);
        n_sent++;
      end
      if (!cmd_valid || !cmd_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_valid <= 1'b0;
        end else if (pending_cmds.size() > 0 && !(pending_cmds[0].wait_empty &&
                     (expected_results.size() != 0 || cmd_valid))) begin
          if (pending_cmds[0].wait_empty) n_pauses++;
          cmd_valid    <= 1'b1;
          cmd          <= pending_cmds[0].op;
          new_block_id <= pending_cmds[0].id;
          new_payload  <= pending_cmds[0].pay;
          robot_idle   <= pending_cmds[0].idle;
          void'(pending_cmds.pop_front());
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with two long holds to back the block up
  int stall_mode = 0, hold_left = 0, rcv_cyc = 0;

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      rcv_cyc++;
      if (rcv_cyc % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left == 0 && ((n_got >= 150 && n_long_holds == 0) ||
                             (n_got >= 800 && n_long_holds == 1))) begin
        hold_left = 250;
        n_long_holds++;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0:       res_stall <= 1'b0;
          1:       res_stall <= ($urandom_range(0, 9) < 3);
          2:       res_stall <= ($urandom_range(0, 9) < 8);
          default: res_stall <= ((rcv_cyc % 5) < 2);
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cq_result_t act, exp_r;
    if (!rst && res_valid && !res_stall) begin
      n_got++;
      act = {status_t'(status), block_valid, out_block_id, out_payload,
             done_valid, done_id, queued_count, running_id};
      if (expected_results.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("result item with nothing expected: %h", act);
      end else begin
        exp_r = expected_results.pop_front();
        if (act !== exp_r) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("mismatch at result %0d", n_got);
            $display("  exp st=%0d bv=%b bid=%h pay=%h dv=%b did=%h cnt=%0d run=%h",
                     exp_r.status, exp_r.block_valid, exp_r.block_id, exp_r.payload,
                     exp_r.done_valid, exp_r.done_id, exp_r.queued, exp_r.running);
            $display("  got st=%0d bv=%b bid=%h pay=%h dv=%b did=%h cnt=%0d run=%h",
                     act.status, act.block_valid, act.block_id, act.payload,
                     act.done_valid, act.done_id, act.queued, act.running);
          end
        end
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_nonzero_id();
    logic [31:0] v;
    v = $urandom;
    return (v == 0) ? 32'h1 : v;
  endfunction

  function automatic cmd_t pick_mixed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return CMD_ADD;
    if (r < 55) return CMD_DISPATCH;
    if (r < 70) return CMD_FINISH;
    if (r < 80) return CMD_ISR_POP;
    if (r < 94) return CMD_DRAIN;
    if (r < 97) return CMD_FLUSH_NEXT;
    return CMD_FLUSH;
  endfunction

  task automatic queue_cmd(input cmd_t op, input logic [31:0] id, input logic [31:0] pay,
                           input logic idle, input bit wait_empty);
    cmd_item_t it;
    it.op = op; it.id = id; it.pay = pay; it.idle = idle; it.wait_empty = wait_empty;
    pending_cmds.push_back(it);
  endtask

  task automatic add_mixed(input int n, input bit pause_first);
    for (int i = 0; i < n; i++)
      queue_cmd(pick_mixed(), rand_word(), rand_word(), $urandom_range(0, 3) != 0,
                pause_first && i == 0);
  endtask

  task automatic add_noise(input int n);
    for (int i = 0; i < n; i++)
      queue_cmd(cmd_t'($urandom_range(0, 6)), $urandom, $urandom, $urandom_range(0, 1), 0);
  endtask

  // fill the queue past full, then pop from it with some drains mixed in
  task automatic add_queue_fill(input bit pause_first);
    queue_cmd(CMD_FLUSH, $urandom, $urandom, 1'b1, pause_first);
    for (int i = 0; i < QUEUE_DEPTH + 3; i++)
      queue_cmd(CMD_ADD, rand_word(), rand_word(), $urandom_range(0, 1), 0);
    for (int i = 0; i < QUEUE_DEPTH + 2; i++)
      queue_cmd(($urandom_range(0, 4) == 0) ? CMD_DRAIN : CMD_ISR_POP,
                $urandom, $urandom, $urandom_range(0, 1), 0);
  endtask

  // run enough blocks to completion that the done ring overflows
  task automatic add_done_fill();
    queue_cmd(CMD_FLUSH, $urandom, $urandom, 1'b1, 0);
    for (int i = 0; i < DONE_DEPTH + 3; i++) begin
      queue_cmd(CMD_ADD, rand_nonzero_id(), $urandom, 1'b1, 0);
      if ($urandom_range(0, 1)) queue_cmd(CMD_DISPATCH, $urandom, $urandom, 1'b1, 0);
      else queue_cmd(CMD_ISR_POP, $urandom, $urandom, $urandom_range(0, 1), 0);
      queue_cmd(CMD_FINISH, $urandom, $urandom, $urandom_range(0, 1), 0);
    end
    for (int i = 0; i < 40; i++)
      queue_cmd(CMD_DRAIN, $urandom, $urandom, $urandom_range(0, 1), 0);
  endtask

  initial begin
    int  cyc;
    bit  timed_out;
    timed_out = 0;

    // directed opening
    queue_cmd(CMD_DRAIN,      32'h0, 32'h0, 1'b1, 0);   // empty done ring
    queue_cmd(CMD_DISPATCH,   32'h0, 32'h0, 1'b1, 0);   // empty queue
    queue_cmd(CMD_ISR_POP,    32'h0, 32'h0, 1'b0, 0);
    queue_cmd(CMD_FINISH,     32'h0, 32'h0, 1'b0, 0);   // nothing running
    queue_cmd(CMD_ADD,        32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 0);
    queue_cmd(CMD_ADD,        32'h0, 32'h0, 1'b0, 0);   // id zero block
    queue_cmd(CMD_ADD,        32'h1, 32'h8000_0000, 1'b1, 0);
    queue_cmd(CMD_DISPATCH,   32'h0, 32'h0, 1'b0, 0);   // robot busy
    queue_cmd(CMD_DISPATCH,   32'h0, 32'h0, 1'b1, 0);
    queue_cmd(CMD_DISPATCH,   32'h0, 32'h0, 1'b1, 0);   // already running
    queue_cmd(CMD_FINISH,     32'h0, 32'h0, 1'b1, 0);
    queue_cmd(CMD_ISR_POP,    32'h0, 32'h0, 1'b0, 0);   // takes id zero, none running
    queue_cmd(CMD_FINISH,     32'h0, 32'h0, 1'b0, 0);
    queue_cmd(CMD_DISPATCH,   32'h0, 32'h0, 1'b1, 0);
    queue_cmd(CMD_ISR_POP,    32'h0, 32'h0, 1'b1, 0);   // empty, running kept
    queue_cmd(CMD_FINISH,     32'h0, 32'h0, 1'b1, 0);
    queue_cmd(CMD_DRAIN,      32'h0, 32'h0, 1'b0, 0);
    queue_cmd(CMD_DRAIN,      32'h0, 32'h0, 1'b0, 0);
    queue_cmd(CMD_DRAIN,      32'h0, 32'h0, 1'b0, 0);
    queue_cmd(CMD_ADD,        32'h1234_5678, 32'h0000_0001, 1'b1, 0);
    queue_cmd(CMD_ADD,        32'h8765_4321, 32'h7FFF_FFFF, 1'b1, 0);
    queue_cmd(CMD_ISR_POP,    32'h0, 32'h0, 1'b1, 0);
    queue_cmd(CMD_FLUSH_NEXT, 32'h0, 32'h0, 1'b1, 0);   // running kept
    queue_cmd(CMD_ADD,        32'h5555_AAAA, 32'hAAAA_5555, 1'b1, 0);
    queue_cmd(CMD_FLUSH,      32'h0, 32'h0, 1'b1, 0);   // running cleared

    // random part
    add_mixed(150, 1);
    add_queue_fill(1);
    add_mixed(100, 0);
    add_done_fill();
    while (pending_cmds.size() < 1300) begin
      case ($urandom_range(0, 5))
        0:       add_noise($urandom_range(10, 30));
        1:       add_queue_fill($urandom_range(0, 2) == 0);
        default: add_mixed($urandom_range(20, 80), $urandom_range(0, 2) == 0);
      endcase
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    cyc = 0;
    while ((pending_cmds.size() != 0 || cmd_valid) && cyc < MaxCycles) begin
      @(posedge clk);
      cyc++;
    end
    while (expected_results.size() != 0 && cyc < MaxCycles) begin
      @(posedge clk);
      cyc++;
    end
    if (cyc >= MaxCycles) timed_out = 1;
    repeat (10) @(posedge clk);

    if (expected_results.size() != 0)
      $display("%0d expected results never arrived", expected_results.size());
    $display("ran %0d commands: %0d blocks handed out, %0d full rejects, %0d ids drained",
             n_sent, n_taken, n_full, n_drained);
    $display("done ring overflows %0d, long receiver holds %0d, sender pauses %0d, errors %0d",
             n_dropped, n_long_holds, n_pauses, n_bad);
    if (!timed_out && n_bad == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout waiting for results");
    $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
rtl/cqd_pkg.sv
rtl/cqd_ram.sv
rtl/command_queue_with_done_fifo.sv
dv/tb.sv
